### rtl/line_tracking_pid_steering_core_defines.svh
// Assertion macros for the port-level checker file of the steering core.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef LINE_TRACKING_PID_STEERING_CORE_DEFINES_SVH
`define LINE_TRACKING_PID_STEERING_CORE_DEFINES_SVH

// same-cycle implication
`define LTPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LTPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ltps_pkg.sv
// Shared types, constants and tables for the line tracking PID steering core.
// No dependencies; the register file, sequencer, datapath, top level and testbench import it.
`default_nettype none

package ltps_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 25;
  localparam int DIV_STEPS    = 58;

  localparam logic [29:0] CORDIC_K = 30'd652032874;  // CORDIC gain inverse, Q30

  localparam logic [23:0] KP_RESET      = 24'd327680;
  localparam logic [23:0] KI_RESET      = 24'd66;
  localparam logic [23:0] KD_RESET      = 24'd721;
  localparam logic [23:0] TS_RESET      = 24'd32768;
  localparam logic [14:0] PREVIEW_RESET = 15'd512;
  localparam logic [14:0] LIMIT_RESET   = 15'd13107;

  typedef enum logic [2:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_TS      = 3'd3,
    REG_PREVIEW = 3'd4,
    REG_LIMIT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] kp;
    logic [23:0] ki;
    logic [23:0] kd;
    logic [23:0] ts;
    logic [14:0] preview;
    logic [14:0] rate_limit;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_KMUL, OP_CORDIC, OP_PREVIEW, OP_NUM_A, OP_NUM_B,
    OP_L2_A, OP_L2_B, OP_SQRT_INIT, OP_SQRT, OP_DIVE_INIT, OP_DIV, OP_E_FIN,
    OP_MUL_P, OP_MUL_KI, OP_MUL_I0, OP_MUL_I1, OP_I_FIN, OP_MUL_D,
    OP_DIVD_INIT, OP_D_FIN, OP_SUM, OP_RATE, OP_DEGEN, OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_KMUL, ST_CORDIC, ST_PREVIEW, ST_NUM_A, ST_NUM_B, ST_L2_A,
    ST_L2_B, ST_CHECK, ST_SQRT_INIT, ST_SQRT, ST_DIVE_INIT, ST_DIVE, ST_E_FIN,
    ST_MUL_P, ST_MUL_KI, ST_MUL_I0, ST_MUL_I1, ST_I_FIN, ST_MUL_D,
    ST_DIVD_INIT, ST_DIVD, ST_D_FIN, ST_SUM, ST_RATE, ST_DEGEN, ST_FIN
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] step;
  } cmd_t;

  typedef struct packed {
    logic l2_zero;
    logic out_busy;
  } stat_t;

  // atan(2^-i) with a full turn as 2^32
  function automatic logic [29:0] atan_entry(input logic [3:0] i);
    logic [29:0] v;
    case (i)
      4'd0:    v = 30'h20000000;
      4'd1:    v = 30'h12E4051E;
      4'd2:    v = 30'h09FB385B;
      4'd3:    v = 30'h051111D4;
      4'd4:    v = 30'h028B0D43;
      4'd5:    v = 30'h0145D7E1;
      4'd6:    v = 30'h00A2F61E;
      4'd7:    v = 30'h00517C55;
      4'd8:    v = 30'h0028BE53;
      4'd9:    v = 30'h00145F2F;
      4'd10:   v = 30'h000A2F98;
      4'd11:   v = 30'h000517CC;
      4'd12:   v = 30'h00028BE6;
      4'd13:   v = 30'h000145F3;
      4'd14:   v = 30'h0000A2FA;
      default: v = 30'h0000517D;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/ltps_if.sv
// Valid/ready channel interfaces for pose items and steering results.
// Payload fields follow the block's input and result items.
`default_nettype none

interface ltps_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic        [15:0] heading;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;

  modport source (output valid, pos_x, pos_y, heading, start_x, start_y, end_x, end_y,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, start_x, start_y, end_x, end_y,
                  output ready);
endinterface

interface ltps_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angular_rate;
  logic signed [15:0] line_error;
  logic               degenerate_line;
  logic               rate_clamped;

  modport source (output valid, angular_rate, line_error, degenerate_line, rate_clamped,
                  input ready);
  modport sink   (input valid, angular_rate, line_error, degenerate_line, rate_clamped,
                  output ready);
endinterface

`default_nettype wire

### rtl/ltps_regs.sv
// APB-style register file holding gains, period, preview distance and limit.
// Depends on ltps_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module ltps_regs
  import ltps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp         <= KP_RESET;
      cfg_r.ki         <= KI_RESET;
      cfg_r.kd         <= KD_RESET;
      cfg_r.ts         <= TS_RESET;
      cfg_r.preview    <= PREVIEW_RESET;
      cfg_r.rate_limit <= LIMIT_RESET;
    end else if (wr) begin
      case (idx)
        REG_KP:      cfg_r.kp         <= cfg_pwdata[23:0];
        REG_KI:      cfg_r.ki         <= cfg_pwdata[23:0];
        REG_KD:      cfg_r.kd         <= cfg_pwdata[23:0];
        REG_TS:      cfg_r.ts         <= cfg_pwdata[23:0];
        REG_PREVIEW: cfg_r.preview    <= cfg_pwdata[14:0];
        REG_LIMIT:   cfg_r.rate_limit <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:      cfg_prdata = {8'd0, cfg_r.kp};
      REG_KI:      cfg_prdata = {8'd0, cfg_r.ki};
      REG_KD:      cfg_prdata = {8'd0, cfg_r.kd};
      REG_TS:      cfg_prdata = {8'd0, cfg_r.ts};
      REG_PREVIEW: cfg_prdata = {17'd0, cfg_r.preview};
      REG_LIMIT:   cfg_prdata = {17'd0, cfg_r.rate_limit};
      default:     cfg_prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ltps_ctrl.sv
// Sequencer for the steering datapath: walks one item through its steps.
// Depends on ltps_pkg for state, command and status types.
`default_nettype none

module ltps_ctrl
  import ltps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  stat_t     stat,
  output cmd_t      cmd
);

  localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);
  localparam logic [5:0] SQRT_LAST   = 6'(SQRT_STEPS - 1);
  localparam logic [5:0] DIV_LAST    = 6'(DIV_STEPS - 1);

  state_t     state_r, state_nxt;
  logic [5:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.step  = step_r;
    case (state_r)
      ST_IDLE: begin
        // no item is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_KMUL;
        end
      end
      ST_KMUL: begin
        cmd.op    = OP_KMUL;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (step_r == CORDIC_LAST) state_nxt = ST_PREVIEW;
        else step_nxt = step_r + 6'd1;
      end
      ST_PREVIEW: begin
        cmd.op    = OP_PREVIEW;
        state_nxt = ST_NUM_A;
      end
      ST_NUM_A: begin
        cmd.op    = OP_NUM_A;
        state_nxt = ST_NUM_B;
      end
      ST_NUM_B: begin
        cmd.op    = OP_NUM_B;
        state_nxt = ST_L2_A;
      end
      ST_L2_A: begin
        cmd.op    = OP_L2_A;
        state_nxt = ST_L2_B;
      end
      ST_L2_B: begin
        cmd.op    = OP_L2_B;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = stat.l2_zero ? ST_DEGEN : ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (step_r == SQRT_LAST) state_nxt = ST_DIVE_INIT;
        else step_nxt = step_r + 6'd1;
      end
      ST_DIVE_INIT: begin
        cmd.op    = OP_DIVE_INIT;
        state_nxt = ST_DIVE;
      end
      ST_DIVE: begin
        cmd.op = OP_DIV;
        if (step_r == DIV_LAST) state_nxt = ST_E_FIN;
        else step_nxt = step_r + 6'd1;
      end
      ST_E_FIN: begin
        cmd.op    = OP_E_FIN;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.op    = OP_MUL_P;
        state_nxt = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        cmd.op    = OP_MUL_KI;
        state_nxt = ST_MUL_I0;
      end
      ST_MUL_I0: begin
        cmd.op    = OP_MUL_I0;
        state_nxt = ST_MUL_I1;
      end
      ST_MUL_I1: begin
        cmd.op    = OP_MUL_I1;
        state_nxt = ST_I_FIN;
      end
      ST_I_FIN: begin
        cmd.op    = OP_I_FIN;
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.op    = OP_MUL_D;
        state_nxt = ST_DIVD_INIT;
      end
      ST_DIVD_INIT: begin
        cmd.op    = OP_DIVD_INIT;
        state_nxt = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.op = OP_DIV;
        if (step_r == DIV_LAST) state_nxt = ST_D_FIN;
        else step_nxt = step_r + 6'd1;
      end
      ST_D_FIN: begin
        cmd.op    = OP_D_FIN;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = ST_RATE;
      end
      ST_RATE: begin
        cmd.op    = OP_RATE;
        state_nxt = ST_FIN;
      end
      ST_DEGEN: begin
        cmd.op    = OP_DEGEN;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // wait here until the output register is free
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/ltps_dp.sv
// Datapath: CORDIC preview point, cross-track distance, square root, shared
// divider, PID terms and output register. Depends on ltps_pkg.
`default_nettype none

module ltps_dp
  import ltps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic        [15:0] in_heading,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [15:0] in_end_x,
  input  wire logic signed [15:0] in_end_y,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_angular_rate,
  output logic signed [15:0]      out_line_error,
  output logic                    out_degenerate_line,
  output logic                    out_rate_clamped
);

  localparam logic [65:0] I_LIMIT = 66'd1 << 60;

  logic signed [15:0] pos_x_r, pos_y_r, start_x_r, start_y_r, end_x_r, end_y_r;
  logic        [15:0] heading_r;
  logic               flip_r;
  logic signed [31:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic signed [17:0] px_r, py_r;
  logic signed [37:0] num_r;
  logic        [33:0] l2_r;
  logic        [49:0] sv_r, sr_r, sb_r;
  logic        [57:0] dvd_r;
  logic        [24:0] rem_r, dvs_r;
  logic               neg_r;
  logic signed [15:0] e_r, prev_r;
  logic signed [31:0] integ_r;
  logic signed [40:0] pterm_r;
  logic        [32:0] kits_r;
  logic        [65:0] acc_r;
  logic signed [61:0] iterm_r;
  logic signed [41:0] dprod_r;
  logic signed [58:0] dterm_r;
  logic signed [63:0] sum_r;
  logic signed [15:0] fin_rate_r, fin_err_r;
  logic               fin_degen_r, fin_clamp_r;
  logic               out_valid_r;
  logic signed [15:0] out_rate_r, out_err_r;
  logic               out_degen_r, out_clamp_r;

  function automatic logic signed [17:0] rnd14(input logic signed [31:0] v);
    logic [31:0] m;
    logic [32:0] q;
    m = v[31] ? 32'(-v) : 32'(v);
    q = (33'(m) + 33'd8192) >> 14;
    return v[31] ? -18'(q) : 18'(q);
  endfunction

  // combinational helpers for the current command
  logic               flip_in;
  logic        [15:0] ang_in;
  logic        [44:0] kprod;
  logic signed [31:0] xs, ys, fx, fy;
  logic signed [33:0] at;
  logic signed [16:0] dxl, dyl;
  logic signed [18:0] ax, ay;
  logic signed [37:0] ma, mb;
  logic signed [33:0] sqx, sqy;
  logic        [50:0] sq_try;
  logic        [37:0] nmag;
  logic        [25:0] dtry;
  logic               dge;
  logic        [57:0] q;
  logic signed [15:0] e_nxt;
  logic signed [32:0] isum;
  logic signed [31:0] integ_nxt;
  logic        [31:0] amag;
  logic        [60:0] imag;
  logic signed [16:0] ediff;
  logic        [41:0] dmag;
  logic        [23:0] tsv;
  logic        [63:0] smag;
  logic        [64:0] rq;
  logic               over;
  logic        [15:0] rr;

  always_comb begin
    flip_in = in_heading[15] ^ in_heading[14];
    ang_in  = in_heading ^ {flip_in, 15'd0};
    kprod   = 45'(cfg.preview) * 45'(CORDIC_K);
    xs      = cx_r >>> cmd.step[3:0];
    ys      = cy_r >>> cmd.step[3:0];
    at      = $signed(34'(atan_entry(cmd.step[3:0])));
    fx      = flip_r ? -cx_r : cx_r;
    fy      = flip_r ? -cy_r : cy_r;
    dxl     = 17'(end_x_r) - 17'(start_x_r);
    dyl     = 17'(end_y_r) - 17'(start_y_r);
    ax      = 19'(px_r) - 19'(start_x_r);
    ay      = 19'(py_r) - 19'(start_y_r);
    ma      = 38'(dyl) * 38'(ax);
    mb      = 38'(dxl) * 38'(ay);
    sqx     = 34'(dxl) * 34'(dxl);
    sqy     = 34'(dyl) * 34'(dyl);
    sq_try  = 51'(sr_r) + 51'(sb_r);
    nmag    = num_r[37] ? 38'(-num_r) : 38'(num_r);
    dtry    = {rem_r, dvd_r[57]};
    dge     = dtry >= {1'b0, dvs_r};
    q       = dvd_r;
    if (neg_r) e_nxt = (q >= 58'd32768) ? 16'sh8000 : 16'(~q[15:0] + 16'd1);
    else       e_nxt = (q > 58'd32767) ? 16'sh7fff : q[15:0];
    isum    = 33'(integ_r) + 33'(e_nxt);
    if (isum[32] != isum[31]) integ_nxt = isum[32] ? 32'sh80000000 : 32'sh7fffffff;
    else                      integ_nxt = isum[31:0];
    amag    = integ_r[31] ? 32'(-integ_r) : 32'(integ_r);
    imag    = (acc_r > I_LIMIT) ? 61'(I_LIMIT) : acc_r[60:0];
    ediff   = 17'(e_r) - 17'(prev_r);
    dmag    = dprod_r[41] ? 42'(-dprod_r) : 42'(dprod_r);
    tsv     = (cfg.ts == 24'd0) ? 24'd1 : cfg.ts;
    smag    = sum_r[63] ? 64'(-sum_r) : 64'(sum_r);
    rq      = (65'(smag) + 65'd2048) >> 12;
    over    = rq > 65'(cfg.rate_limit);
    rr      = over ? {1'b0, cfg.rate_limit} : rq[15:0];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        pos_x_r   <= in_pos_x;
        pos_y_r   <= in_pos_y;
        heading_r <= ang_in;
        start_x_r <= in_start_x;
        start_y_r <= in_start_y;
        end_x_r   <= in_end_x;
        end_y_r   <= in_end_y;
        flip_r    <= flip_in;
      end
      OP_KMUL: begin
        cx_r <= $signed({3'd0, kprod[44:16]});
        cy_r <= '0;
        cz_r <= 34'($signed({heading_r, 16'd0}));
      end
      OP_CORDIC: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      OP_PREVIEW: begin
        px_r <= 18'(pos_x_r) + rnd14(fx);
        py_r <= 18'(pos_y_r) + rnd14(fy);
      end
      OP_NUM_A: num_r <= ma;
      OP_NUM_B: num_r <= num_r - mb;
      OP_L2_A:  l2_r  <= 34'(sqx);
      OP_L2_B:  l2_r  <= l2_r + 34'(sqy);
      OP_SQRT_INIT: begin
        sv_r <= {l2_r, 16'd0};
        sr_r <= '0;
        sb_r <= 50'd1 << 48;
      end
      OP_SQRT: begin
        if (51'(sv_r) >= sq_try) begin
          sv_r <= sv_r - sq_try[49:0];
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      OP_DIVE_INIT: begin
        dvd_r <= 58'({nmag, 8'd0}) + 58'(sr_r[24:1]);
        rem_r <= '0;
        dvs_r <= sr_r[24:0];
        neg_r <= num_r[37];
      end
      OP_DIV: begin
        rem_r <= dge ? 25'(dtry - {1'b0, dvs_r}) : dtry[24:0];
        dvd_r <= {dvd_r[56:0], dge};
      end
      OP_MUL_P:  pterm_r <= 41'(e_r) * 41'($signed({1'b0, cfg.kp}));
      OP_MUL_KI: kits_r  <= 33'((48'(cfg.ki) * 48'(cfg.ts) + 48'd32768) >> 16);
      OP_MUL_I0: acc_r   <= 66'(amag) * 66'(kits_r[15:0]);
      OP_MUL_I1: acc_r   <= acc_r + ((66'(amag) * 66'(kits_r[32:16])) << 16);
      OP_I_FIN:  iterm_r <= integ_r[31] ? -62'(imag) : 62'(imag);
      OP_MUL_D:  dprod_r <= 42'(ediff) * 42'($signed({1'b0, cfg.kd}));
      OP_DIVD_INIT: begin
        dvd_r <= {dmag, 16'd0} + 58'(tsv >> 1);
        rem_r <= '0;
        dvs_r <= 25'(tsv);
        neg_r <= dprod_r[41];
      end
      OP_D_FIN: dterm_r <= neg_r ? -59'(dvd_r) : 59'(dvd_r);
      OP_SUM:   sum_r   <= 64'(pterm_r) + 64'(iterm_r) + 64'(dterm_r);
      OP_RATE: begin
        fin_rate_r  <= sum_r[63] ? 16'(~rr + 16'd1) : rr;
        fin_err_r   <= e_r;
        fin_degen_r <= 1'b0;
        fin_clamp_r <= over;
      end
      OP_DEGEN: begin
        fin_rate_r  <= '0;
        fin_err_r   <= '0;
        fin_degen_r <= 1'b1;
        fin_clamp_r <= 1'b0;
      end
      OP_OUT: begin
        out_rate_r  <= fin_rate_r;
        out_err_r   <= fin_err_r;
        out_degen_r <= fin_degen_r;
        out_clamp_r <= fin_clamp_r;
      end
      default: ;
    endcase
  end

  // controller state carried across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r     <= '0;
      prev_r  <= '0;
      integ_r <= '0;
    end else if (cmd.op == OP_E_FIN) begin
      e_r     <= e_nxt;
      integ_r <= integ_nxt;
    end else if (cmd.op == OP_DIVD_INIT) begin
      prev_r  <= e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)                out_valid_r <= 1'b0;
    else if (cmd.op == OP_OUT) out_valid_r <= 1'b1;
    else if (out_ready)        out_valid_r <= 1'b0;
  end

  assign stat.l2_zero        = (l2_r == 34'd0);
  assign stat.out_busy       = out_valid_r && !out_ready;
  assign out_valid           = out_valid_r;
  assign out_angular_rate    = out_rate_r;
  assign out_line_error      = out_err_r;
  assign out_degenerate_line = out_degen_r;
  assign out_rate_clamped    = out_clamp_r;

endmodule

`default_nettype wire

### rtl/line_tracking_pid_steering_core.sv
// Line tracking PID steering core. One item is one control tick: pose and line
// segment in, one steering result out. Items are handled one at a time; a
// zero-length line skips the square root, the divisions and the PID terms.
// Each normal item runs the shared restoring divider (58 steps, run once for
// the line distance and once for the derivative term), the 25-step square root
// of the squared line length and the 16-step CORDIC for the preview point.
// A finished result sits in the output register while the next item is
// taken. Registers are written over the APB-style cfg_ port at 4*index.
`default_nettype none

module line_tracking_pid_steering_core
  import ltps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  ltps_in_if.sink          in_ch,
  ltps_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  ltps_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ltps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ltps_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .stat                (stat),
    .in_pos_x            (in_ch.pos_x),
    .in_pos_y            (in_ch.pos_y),
    .in_heading          (in_ch.heading),
    .in_start_x          (in_ch.start_x),
    .in_start_y          (in_ch.start_y),
    .in_end_x            (in_ch.end_x),
    .in_end_y            (in_ch.end_y),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_angular_rate    (out_ch.angular_rate),
    .out_line_error      (out_ch.line_error),
    .out_degenerate_line (out_ch.degenerate_line),
    .out_rate_clamped    (out_ch.rate_clamped)
  );

endmodule

`default_nettype wire

### rtl/ltps_chk.sv
// Port-level checker for the steering core, attached by bind below.
// Uses the assertion macros of line_tracking_pid_steering_core_defines.svh.
`default_nettype none
`include "line_tracking_pid_steering_core_defines.svh"

module ltps_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_rate,
  input wire logic signed [15:0] out_err,
  input wire logic               out_degen,
  input wire logic               out_clamp
);

  `LTPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rate) && $stable(out_err) && $stable(out_degen) && $stable(out_clamp), "result changed while stalled")
  `LTPS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `LTPS_ASSERT_NOW(a_degen_zero, out_valid && out_degen, out_rate == 16'sd0 && out_err == 16'sd0 && !out_clamp, "zero-length line result not cleared")

endmodule

bind line_tracking_pid_steering_core ltps_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rate  (out_ch.angular_rate),
  .out_err   (out_ch.line_error),
  .out_degen (out_ch.degenerate_line),
  .out_clamp (out_ch.rate_clamped)
);

`default_nettype wire

### tb/tb_line_tracking_pid_steering_core.sv
// Self-checking testbench for the line tracking PID steering core.
// Needs ltps_pkg, the ltps_in_if/ltps_out_if channels and the core RTL.
`default_nettype none

module tb_line_tracking_pid_steering_core;
  import ltps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  DRAIN_CYCLES   = 400;
  localparam int  HOLD_CYCLES    = 500;
  localparam int  REG_UNUSED     = 7;   // no register behind this index
  localparam longint unsigned CORDIC_GAIN_Q30 = 64'd652032874;
  localparam longint ATAN_Q32 [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] heading;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] angular_rate;
    logic signed [15:0] line_error;
    logic               degenerate_line;
    logic               rate_clamped;
  } steer_t;

  // Steering predictor plus queue of pending steering results
  class steer_scoreboard;
    longint unsigned kp, ki, kd, ts, preview, limit;
    longint          last_err, err_sum;
    steer_t          pending_q[$];
    int              errors;

    function new();
      kp = KP_RESET; ki = KI_RESET; kd = KD_RESET; ts = TS_RESET;
      preview = PREVIEW_RESET; limit = LIMIT_RESET;
      last_err = 0; err_sum = 0; errors = 0;
    endfunction

    function void set_reg(int idx, longint unsigned val);
      case (idx)
        REG_KP:      kp = val & 64'hFFFFFF;
        REG_KI:      ki = val & 64'hFFFFFF;
        REG_KD:      kd = val & 64'hFFFFFF;
        REG_TS:      ts = val & 64'hFFFFFF;
        REG_PREVIEW: preview = val & 64'h7FFF;
        REG_LIMIT:   limit = val & 64'h7FFF;
        default: ;
      endcase
    endfunction

    // divide rounding half away from zero, den > 0
    function longint round_div(longint num, longint den);
      longint unsigned mag, q;
      mag = num < 0 ? longint'(0) - num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note_input(pose_t p);
      logic [31:0]     ang;
      logic            flip;
      int signed       ang_s;
      longint          x, y, z, xs, ys, px, py, dxl, dyl, l2, num, s, e;
      longint          pterm, iterm, dterm, sum, rate, tsd;
      longint unsigned kits, amag, imag;
      steer_t          r;

      ang = {p.heading, 16'h0000};
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang - 32'h80000000;
      ang_s = ang;
      z = ang_s;
      x = (preview * CORDIC_GAIN_Q30) >> 16;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - ATAN_Q32[i];
        end else begin
          x = x + ys; y = y - xs; z = z + ATAN_Q32[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      px = longint'(p.pos_x) + round_div(x, 16384);
      py = longint'(p.pos_y) + round_div(y, 16384);
      dxl = longint'(p.end_x) - longint'(p.start_x);
      dyl = longint'(p.end_y) - longint'(p.start_y);
      l2 = dxl * dxl + dyl * dyl;
      r = '0;
      if (l2 == 0) begin
        r.degenerate_line = 1'b1;   // state untouched on a zero-length line
      end else begin
        num = dyl * (px - longint'(p.start_x)) - dxl * (py - longint'(p.start_y));
        s = sqrt_floor(longint'(l2) << 16);
        e = clip(round_div(num * 256, s), -32768, 32767);
        err_sum = clip(err_sum + e, -64'sd2147483648, 64'sd2147483647);
        pterm = e * longint'(kp);
        kits = (ki * ts + 32768) >> 16;
        amag = err_sum < 0 ? -err_sum : err_sum;
        imag = amag * kits;
        if (imag > (64'd1 << 60)) imag = 64'd1 << 60;
        iterm = err_sum < 0 ? -longint'(imag) : longint'(imag);
        tsd = ts == 0 ? 1 : longint'(ts);
        dterm = round_div((e - last_err) * longint'(kd) * 65536, tsd);
        last_err = e;
        sum = pterm + iterm + dterm;
        rate = round_div(sum, 4096);
        if (rate > longint'(limit)) begin
          rate = limit; r.rate_clamped = 1'b1;
        end
        if (rate < -longint'(limit)) begin
          rate = -longint'(limit); r.rate_clamped = 1'b1;
        end
        r.angular_rate = rate[15:0];
        r.line_error = e[15:0];
      end
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(steer_t got);
      steer_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result rate=%0d err=%0d",
                                   got.angular_rate, got.line_error);
        return;
      end
      want = pending_q.pop_front();
      if (got.angular_rate !== want.angular_rate || got.line_error !== want.line_error ||
          got.degenerate_line !== want.degenerate_line ||
          got.rate_clamped !== want.rate_clamped) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: rate %0d/%0d err %0d/%0d degen %b/%b clamp %b/%b (exp/act)",
                   want.angular_rate, got.angular_rate, want.line_error, got.line_error,
                   want.degenerate_line, got.degenerate_line,
                   want.rate_clamped, got.rate_clamped);
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ltps_in_if  in_ch ();
  ltps_out_if out_ch ();

  line_tracking_pid_steering_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  steer_scoreboard sb = new();
  bit quiet;      // no idling on either side
  bit hold_rx;    // long receiver hold-off
  int sent_cnt;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx * 4); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic wait_drained();
    // the last item was taken; stop offering it again
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_all(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd,
                         logic [23:0] ts, logic [14:0] pv, logic [14:0] lim);
    wait_drained();
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_TS, ts);
    write_reg(REG_PREVIEW, pv);
    write_reg(REG_LIMIT, lim);
  endtask

  task automatic send_pose(pose_t p);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pos_x   <= p.pos_x;   in_ch.pos_y   <= p.pos_y;
    in_ch.heading <= p.heading;
    in_ch.start_x <= p.start_x; in_ch.start_y <= p.start_y;
    in_ch.end_x   <= p.end_x;   in_ch.end_y   <= p.end_y;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(p);
    sent_cnt++;
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    int    k;
    p = pose_t'({$urandom, $urandom, $urandom, 16'($urandom)});
    k = $urandom_range(0, 19);
    if (k < 13) begin
      // tracking a line: pose close to a moderate segment
      p.start_x = 16'($signed($urandom_range(0, 16000)) - 8000);
      p.start_y = 16'($signed($urandom_range(0, 16000)) - 8000);
      p.end_x   = p.start_x + 16'($signed($urandom_range(0, 8000)) - 4000);
      p.end_y   = p.start_y + 16'($signed($urandom_range(0, 8000)) - 4000);
      p.pos_x   = p.start_x + 16'($signed($urandom_range(0, 2000)) - 1000);
      p.pos_y   = p.start_y + 16'($signed($urandom_range(0, 2000)) - 1000);
    end else if (k == 13) begin
      p.end_x = p.start_x;
      p.end_y = p.start_y;
    end
    return p;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_pose(random_pose());
  endtask

  task automatic run_directed();
    pose_t p;
    logic [15:0] hd [6] = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd8192};
    foreach (hd[i]) begin
      p = '{16'sd0, 16'sd100, hd[i], -16'sd1000, 16'sd0, 16'sd1000, 16'sd0};
      send_pose(p);
    end
    // coordinate extremes, saturated error
    send_pose('{16'h7FFF, 16'h7FFF, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000});
    send_pose('{16'h8000, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000});
    send_pose('{16'h7FFF, 16'h8000, 16'h4000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
    send_pose('{16'h8000, 16'h7FFF, 16'hC000, 16'h0000, 16'h0000, 16'h0001, 16'h0000});
    // zero-length lines, at the extremes too
    send_pose('{16'sd5, 16'sd5, 16'h1234, 16'sd7, 16'sd7, 16'sd7, 16'sd7});
    send_pose('{16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_pose('{16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    // same error repeated so the integral builds, then the sign flips
    for (int i = 0; i < 5; i++)
      send_pose('{16'sd0, 16'sd3000, 16'h0000, -16'sd500, 16'sd0, 16'sd500, 16'sd0});
    for (int i = 0; i < 3; i++)
      send_pose('{16'sd0, -16'sd3000, 16'h0000, -16'sd500, 16'sd0, 16'sd500, 16'sd0});
  endtask

  // result side: random stalls, long hold-off when asked
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.angular_rate, out_ch.line_error,
                          out_ch.degenerate_line, out_ch.rate_clamped});
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 13);
      out_ch.ready <= !hold_rx && stall == 0;
    end
  end

  initial begin
    hold_rx = 1'b0;
    wait (sent_cnt >= 120);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (!in_ch.valid && sb.pending() == 0) || cfg_psel)
        idle = 0;
      else
        idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    sent_cnt = 0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.pos_x, in_ch.pos_y, in_ch.heading, in_ch.start_x, in_ch.start_y,
     in_ch.end_x, in_ch.end_y} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(200);
    wait_drained();           // sender waits for every pending result
    run_random(200);

    set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 15'h7FFF, 15'h7FFF);
    run_random(200);
    set_all(24'd0, 24'd0, 24'd0, 24'hFFFFFF, 15'd0, 15'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    run_random(150);
    for (int ph = 0; ph < 3; ph++) begin
      set_all(24'($urandom_range(0, 24'h0FFFFF)), 24'($urandom_range(0, 24'h00FFFF)),
              24'($urandom_range(0, 24'h0FFFFF)), 24'($urandom_range(1, 24'hFFFFFF)),
              15'($urandom), 15'($urandom));
      run_random(300);
    end
    set_all(24'd131072, 24'd2000, 24'd5000, 24'd8192, 15'd2048, 15'd20000);
    quiet = 1'b1;
    run_random(300);

    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
